>>> rtl/core/ascii_brightness_command_parser_defines.svh
// assertion macros for the ascii brightness command parser
`ifndef ASCII_BRIGHTNESS_COMMAND_PARSER_DEFINES_SVH
`define ASCII_BRIGHTNESS_COMMAND_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// implication or plain property, checked on every rising clock edge outside reset
`define ABCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("abcp assertion failed");

// condition that must never be seen outside reset
`define ABCP_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("abcp forbidden condition seen");

`else

`define ABCP_ASSERT(label, clk, rst, prop)
`define ABCP_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

>>> rtl/core/abcp_pkg.sv
// shared types, codes and helpers for the ascii brightness command parser
`timescale 1ns / 1ps
`default_nettype none

package abcp_pkg;

   // line length limit; the counter is wide enough for any limit up to 31
   localparam int MaxLine    = 19;
   localparam int CountWidth = 5;
   localparam int MagWidth   = 7;
   localparam int DutyWidth  = 8;

   localparam logic [CountWidth-1:0] MaxLineCount = CountWidth'(MaxLine);
   localparam logic [CountWidth-1:0] LenOn        = CountWidth'(2);
   localparam logic [CountWidth-1:0] LenOff       = CountWidth'(3);

   // result status codes
   localparam logic [1:0] StatusOn      = 2'd0;
   localparam logic [1:0] StatusOff     = 2'd1;
   localparam logic [1:0] StatusLevel   = 2'd2;
   localparam logic [1:0] StatusInvalid = 2'd3;

   // number scan phases
   localparam logic [1:0] PhaseSkip   = 2'd0;
   localparam logic [1:0] PhaseSign   = 2'd1;
   localparam logic [1:0] PhaseDigits = 2'd2;
   localparam logic [1:0] PhaseDone   = 2'd3;

   // magnitude limits
   localparam logic [MagWidth-1:0]  MagMax   = MagWidth'(100);
   localparam logic [MagWidth-1:0]  MagOver  = MagWidth'(101);
   localparam logic [DutyWidth-1:0] DutyFull = 8'hFF;
   localparam logic [DutyWidth-1:0] DutyZero = 8'h00;

   // characters
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChVt    = 8'h0B;
   localparam logic [7:0] ChFf    = 8'h0C;
   localparam logic [7:0] ChPlus  = 8'h2B;
   localparam logic [7:0] ChMinus = 8'h2D;
   localparam logic [7:0] ChZero  = 8'h30;
   localparam logic [7:0] ChNine  = 8'h39;
   localparam logic [7:0] ChO     = 8'h4F;
   localparam logic [7:0] ChN     = 8'h4E;
   localparam logic [7:0] ChF     = 8'h46;

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic                  may_on;
      logic                  may_off;
      logic [1:0]            phase;
      logic                  negative;
      logic [MagWidth-1:0]   mag;
   } line_state_type;

   typedef struct packed {
      line_state_type line;
      logic           done;
   } scan_result_type;

   localparam line_state_type LineClear = '{
      count:    '0,
      may_on:   1'b1,
      may_off:  1'b1,
      phase:    PhaseSkip,
      negative: 1'b0,
      mag:      '0
   };

   // floor(level * 255 / 100) for level 0..100, as level * 10445 / 4096
   function automatic logic [DutyWidth-1:0] duty_of(input logic [MagWidth-1:0] level);
      logic [19:0] prod;
      prod = 20'(level) * 20'd10445;
      return prod[19:12];
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/abcp_scan.sv
// one character step of the command line scanner
`timescale 1ns / 1ps
`default_nettype none

module abcp_scan (
   input  wire logic [7:0]              rx_byte,
   input  wire abcp_pkg::line_state_type line_i,
   output abcp_pkg::scan_result_type    scan_o
);

   abcp_pkg::line_state_type nxt;
   logic                     eol;
   logic                     digit;
   logic [3:0]               dval;
   logic [10:0]              acc;
   logic [7:0]               off_ch;

   always_comb begin
      eol   = rx_byte inside {abcp_pkg::ChCr, abcp_pkg::ChLf};
      digit = rx_byte inside {[abcp_pkg::ChZero:abcp_pkg::ChNine]};
      dval  = rx_byte[3:0];
      acc   = {1'b0, line_i.mag, 3'b000} + {3'b000, line_i.mag, 1'b0} + {7'd0, dval};

      case (line_i.count)
         5'd0:    off_ch = abcp_pkg::ChO;
         default: off_ch = abcp_pkg::ChF;
      endcase

      nxt = line_i;

      // keyword prefix tracking
      if (line_i.count >= abcp_pkg::LenOn ||
          rx_byte != (line_i.count[0] ? abcp_pkg::ChN : abcp_pkg::ChO)) begin
         nxt.may_on = 1'b0;
      end
      if (line_i.count >= abcp_pkg::LenOff || rx_byte != off_ch) begin
         nxt.may_off = 1'b0;
      end

      // decimal scan
      case (line_i.phase)
         abcp_pkg::PhaseSkip: begin
            if (rx_byte inside {abcp_pkg::ChSpace, abcp_pkg::ChTab,
                                abcp_pkg::ChVt, abcp_pkg::ChFf}) begin
               nxt.phase = abcp_pkg::PhaseSkip;
            end else if (rx_byte inside {abcp_pkg::ChPlus, abcp_pkg::ChMinus}) begin
               nxt.negative = (rx_byte == abcp_pkg::ChMinus);
               nxt.phase    = abcp_pkg::PhaseSign;
            end else if (digit) begin
               nxt.mag   = {3'b000, dval};
               nxt.phase = abcp_pkg::PhaseDigits;
            end else begin
               nxt.phase = abcp_pkg::PhaseDone;
            end
         end
         abcp_pkg::PhaseSign, abcp_pkg::PhaseDigits: begin
            if (digit) begin
               nxt.mag   = (acc > 11'(abcp_pkg::MagMax)) ? abcp_pkg::MagOver : acc[6:0];
               nxt.phase = abcp_pkg::PhaseDigits;
            end else begin
               nxt.phase = abcp_pkg::PhaseDone;
            end
         end
         default: begin
            nxt.phase = line_i.phase;
         end
      endcase

      nxt.count = line_i.count + 5'd1;

      if (eol) begin
         scan_o.line = line_i;
         scan_o.done = (line_i.count != '0);
      end else begin
         scan_o.line = nxt;
         scan_o.done = (nxt.count >= abcp_pkg::MaxLineCount);
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ascii_brightness_command_parser.sv
// top level of the ascii brightness command parser
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_brightness_command_parser_defines.svh"

// Takes one received byte per request and gathers a command line, which ends
// at CR or LF or right after its 19th character. A finished line gives one
// response: exact "ON" (status 0, duty 255), exact "OFF" (status 1, duty 0),
// a decimal 0..100 read atoi style (status 2, duty = level*255/100 rounded
// down) or anything else (status 3, duty unchanged, level 0). An empty line,
// such as the LF after a CR, gives no response. One byte is taken every cycle
// unless stalled; a byte sits in the input register and is judged in the cycle
// after its accept, so its response, if any, passes from the input register to
// the response register, where rsp_valid shows it. The only stall is a finishing
// byte meeting a full, untaken response register.
module ascii_brightness_command_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [1:0] rsp_status,
   output      logic [6:0] rsp_level_percent,
   output      logic [7:0] rsp_pwm_duty
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // line state and current duty
   abcp_pkg::line_state_type line_ff, line_in;
   logic [7:0]               duty_ff, duty_in;

   // response register
   logic       rsp_vld_ff, rsp_vld_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [6:0] rsp_level_ff, rsp_level_in;
   logic [7:0] rsp_duty_ff, rsp_duty_in;

   abcp_pkg::scan_result_type scan;
   logic                      advance;
   logic                      finish;

   // verdict on the judged line
   logic [1:0] v_status;
   logic [6:0] v_level;
   logic [7:0] v_duty;

   abcp_scan u_scan (
      .rx_byte (in_byte_ff),
      .line_i  (line_ff),
      .scan_o  (scan)
   );

   // a byte that finishes no line never waits on the response side
   assign advance   = in_vld_ff && (!scan.done || !rsp_vld_ff || rsp_ready);
   assign finish    = advance && scan.done;
   assign req_ready = !in_vld_ff || advance;

   always_comb begin
      if (scan.line.may_on && scan.line.count == abcp_pkg::LenOn) begin
         v_status = abcp_pkg::StatusOn;
         v_level  = abcp_pkg::MagMax;
         v_duty   = abcp_pkg::DutyFull;
      end else if (scan.line.may_off && scan.line.count == abcp_pkg::LenOff) begin
         v_status = abcp_pkg::StatusOff;
         v_level  = '0;
         v_duty   = abcp_pkg::DutyZero;
      end else if (scan.line.mag > abcp_pkg::MagMax ||
                   (scan.line.negative && scan.line.mag != '0)) begin
         // out of range or negative: duty kept
         v_status = abcp_pkg::StatusInvalid;
         v_level  = '0;
         v_duty   = duty_ff;
      end else begin
         // no digits reads as zero, as does minus zero
         v_status = abcp_pkg::StatusLevel;
         v_level  = scan.line.mag;
         v_duty   = abcp_pkg::duty_of(scan.line.mag);
      end
   end

   always_comb begin
      // input stage
      in_vld_in  = in_vld_ff;
      in_byte_in = in_byte_ff;
      if (req_valid && req_ready) begin
         in_vld_in  = 1'b1;
         in_byte_in = req_rx_byte;
      end else if (advance) begin
         in_vld_in  = 1'b0;
      end

      // line state: cleared once a line is judged
      line_in = line_ff;
      duty_in = duty_ff;
      if (advance) begin
         line_in = scan.done ? abcp_pkg::LineClear : scan.line;
      end
      if (finish) begin
         duty_in = v_duty;
      end

      // response register
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_duty_in   = rsp_duty_ff;
      if (finish) begin
         rsp_vld_in    = 1'b1;
         rsp_status_in = v_status;
         rsp_level_in  = v_level;
         rsp_duty_in   = v_duty;
      end else if (rsp_ready) begin
         rsp_vld_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         line_ff    <= abcp_pkg::LineClear;
         duty_ff    <= abcp_pkg::DutyZero;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         line_ff    <= line_in;
         duty_ff    <= duty_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_duty_ff   <= rsp_duty_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_level_percent = rsp_level_ff;
   assign rsp_pwm_duty      = rsp_duty_ff;

   // a pending response always reports the duty currently held
   `ABCP_ASSERT(a_rsp_duty_tracks, clock, reset, rsp_vld_ff |-> (rsp_duty_ff == duty_ff))
   // an on response carries full level and full duty
   `ABCP_ASSERT(a_on_full, clock, reset, (rsp_vld_ff && rsp_status_ff == abcp_pkg::StatusOn) |-> (rsp_level_ff == abcp_pkg::MagMax && rsp_duty_ff == abcp_pkg::DutyFull))
   // a stored line is always judged before reaching the length limit
   `ABCP_ASSERT_NEVER(a_line_len, clock, reset, line_ff.count >= abcp_pkg::MaxLineCount)

endmodule

`default_nettype wire
